FILE: rtl/core/soa_pkg.sv
// ----------------------------------------------------------------------------
// Slot owner table allocator package
// Shared types and constants for the owner cell row and its controller.
// ----------------------------------------------------------------------------
package soa_pkg;

   localparam int NUM_UNITS   = 16;
   localparam int TASK_BITS   = 16;
   localparam int MAX_OUT     = 16;
   localparam int UNITS_RESET = 16;

   localparam int CNT_W  = $clog2(NUM_UNITS + 1);
   localparam int LIST_W = $clog2(MAX_OUT + 1);
   localparam int UIDX_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

   typedef enum logic [1:0] {
      FUNC_ALLOC = 2'd0,
      FUNC_FREE  = 2'd1,
      FUNC_LIST  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_SHORT  = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   // Request token walking down the cell row.
   typedef struct packed {
      logic                  valid;
      logic                  reject;
      func_type              func;
      logic [TASK_BITS-1:0]  task_id;
      logic [4:0]            want;
      logic [CNT_W-1:0]      cnt;
      logic [LIST_W-1:0]     listed;
   } tok_type;

endpackage

FILE: rtl/core/soa_cell.sv
// ----------------------------------------------------------------------------
// Slot owner cell
// Holds the owner of one unit and applies the passing request token to it.
// ----------------------------------------------------------------------------
module soa_cell
   import soa_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    en,
   input  tok_type tok_prev,
   output tok_type tok_out,
   output logic    hit
);

   logic [TASK_BITS-1:0] entry_ff, entry_in;
   tok_type              tok_ff, tok_in;

   always_comb begin
      tok_in   = tok_prev;
      entry_in = entry_ff;
      hit      = 1'b0;
      if (tok_prev.valid && en && !tok_prev.reject) begin
         unique case (tok_prev.func)
            FUNC_ALLOC: begin
               if (entry_ff == '0 && 32'(tok_prev.cnt) < 32'(tok_prev.want)) begin
                  entry_in   = tok_prev.task_id;
                  tok_in.cnt = CNT_W'(tok_prev.cnt + 1'b1);
               end
            end
            FUNC_FREE: begin
               if (entry_ff == tok_prev.task_id) begin
                  entry_in   = '0;
                  tok_in.cnt = CNT_W'(tok_prev.cnt + 1'b1);
               end
            end
            FUNC_LIST: begin
               if (entry_ff == tok_prev.task_id && 32'(tok_prev.listed) < 32'(MAX_OUT)) begin
                  hit           = 1'b1;
                  tok_in.listed = LIST_W'(tok_prev.listed + 1'b1);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
         tok_ff   <= '0;
      end else if (adv) begin
         entry_ff <= entry_in;
         tok_ff   <= tok_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

FILE: rtl/core/slot_owner_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// Slot owner table allocator
// First-fit unit allocator over a row of owner cells; allocate, free, list.
// ----------------------------------------------------------------------------
//   channel  | direction | tdata (low bit up)                  | tuser / tlast
//   req_     | in        | task_id[15:0], unit_count[4:0], pad | func[1:0] / -
//   rsp_     | out       | status[1:0], unit_index[3:0],       | none_found / last
//            |           | affected[4:0], pad                  |
//   csr_     | in        | units_in_use[4:0]                   | -
//
// A request token walks the cell row one cell per cycle unless the row is
// stalled; the result register loads as the token leaves the last cell, and
// a new request is taken only once the row and its head register are empty.
// A list result is held one step so the final one carries last; a full
// result register stalls the whole row while a result is due. Reset is
// synchronous and clears the owner table, the token and the result valid flag.
// ----------------------------------------------------------------------------
module slot_owner_table_allocator_unit
   import soa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // task_id[15:0], unit_count[20:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // status[1:0], unit_index[5:2], affected[10:6]
   output logic        rsp_tuser,   // none_found
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [4:0]  csr_wdata
);

   tok_type                head_ff, head_in;
   tok_type                tok_prev [NUM_UNITS];
   tok_type                tok_out  [NUM_UNITS];
   tok_type                tail;
   logic [NUM_UNITS-1:0]   hit, en, tok_vld;
   logic [4:0]             units_ff;
   logic                   pend_vld_ff, pend_vld_in;
   logic [UIDX_W-1:0]      pend_idx_ff, pend_idx_in, hit_idx;
   logic                   rsp_vld_ff, rsp_vld_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [3:0]             rsp_index_ff, rsp_index_in;
   logic [4:0]             rsp_affected_ff, rsp_affected_in;
   logic                   rsp_none_ff, rsp_none_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   busy, hit_any, out_free, tail_res, need_emit, adv, req_accept;
   logic [TASK_BITS-1:0]   req_task;
   logic [4:0]             tail_aff;

   genvar g;
   generate
      for (g = 0; g < NUM_UNITS; g++) begin : g_cell
         if (g == 0) begin : g_first
            assign tok_prev[g] = head_ff;
         end else begin : g_next
            assign tok_prev[g] = tok_out[g-1];
         end
         assign en[g]      = 32'(units_ff) > 32'(g);
         assign tok_vld[g] = tok_out[g].valid;
         soa_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .adv      (adv),
            .en       (en[g]),
            .tok_prev (tok_prev[g]),
            .tok_out  (tok_out[g]),
            .hit      (hit[g])
         );
      end
   endgenerate

   assign tail       = tok_out[NUM_UNITS-1];
   assign busy       = head_ff.valid || (|tok_vld);
   assign req_tready = !busy;
   assign req_accept = req_tvalid && req_tready;
   assign req_task   = TASK_BITS'(req_tdata[15:0]);
   assign hit_any    = |hit;
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign tail_res   = tail.valid && tail.func != FUNC_NONE;
   assign need_emit  = (hit_any && pend_vld_ff) || tail_res;
   assign adv        = !need_emit || out_free;
   assign tail_aff   = (32'(tail.cnt) > 32'd31) ? 5'd31 : 5'(tail.cnt);

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < NUM_UNITS; i++) begin
         if (hit[i]) hit_idx = hit_idx | UIDX_W'(i);
      end
   end

   always_comb begin
      head_in = head_ff;
      if (req_accept) begin
         head_in.valid   = 1'b1;
         head_in.reject  = (req_task == '0);
         head_in.func    = func_type'(req_tuser);
         head_in.task_id = req_task;
         head_in.want    = req_tdata[20:16];
         head_in.cnt     = '0;
         head_in.listed  = '0;
      end else if (adv) begin
         head_in.valid = 1'b0;
      end
   end

   always_comb begin
      pend_vld_in = pend_vld_ff;
      pend_idx_in = pend_idx_ff;
      if (adv) begin
         if (hit_any) begin
            pend_vld_in = 1'b1;
            pend_idx_in = hit_idx;
         end else if (tail.valid) begin
            pend_vld_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_vld_in      = rsp_vld_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_affected_in = rsp_affected_ff;
      rsp_none_in     = rsp_none_ff;
      rsp_last_in     = rsp_last_ff;
      if (adv && need_emit) begin
         rsp_vld_in      = 1'b1;
         rsp_status_in   = ST_OK;
         rsp_index_in    = '0;
         rsp_affected_in = '0;
         rsp_none_in     = 1'b0;
         rsp_last_in     = 1'b1;
         if (hit_any) begin
            rsp_index_in = 4'(pend_idx_ff);
            rsp_last_in  = 1'b0;
         end else if (tail.reject) begin
            rsp_status_in = ST_REJECT;
         end else begin
            unique case (tail.func)
               FUNC_ALLOC: begin
                  rsp_status_in   = (32'(tail.cnt) < 32'(tail.want)) ? ST_SHORT : ST_OK;
                  rsp_affected_in = tail_aff;
               end
               FUNC_FREE: rsp_affected_in = tail_aff;
               FUNC_LIST: begin
                  if (pend_vld_ff) rsp_index_in = 4'(pend_idx_ff);
                  else             rsp_none_in  = 1'b1;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         units_ff    <= 5'(UNITS_RESET);
      end else begin
         head_ff     <= head_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_wen) units_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff     <= pend_idx_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_affected_ff <= rsp_affected_in;
      rsp_none_ff     <= rsp_none_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'd0, rsp_affected_ff, rsp_index_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_none_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0({head_ff.valid, tok_vld}))
      else $error("more than one request token in the cell row");

   a_pend_busy: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> busy)
      else $error("pending list result with no request in flight");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("several cells hit in one cycle");
`endif

endmodule
